[rtl/bracket_minimum_search_unit_assert.svh]
// Assertion macros for the bracket minimum search unit.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BRACKET_MINIMUM_SEARCH_UNIT_ASSERT_SVH
`define BRACKET_MINIMUM_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bms assertion failed");
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bms assertion failed");
`else
`define BMS_ASSERT_IMP(lbl, ante, cons)
`define BMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/bms_pkg.sv]
// Types, codes and saturation helpers for the bracket minimum search unit.
// No dependencies.
package bms_pkg;

    localparam int XW = 32;
    localparam int PW = 68;
    localparam int MW = 34;
    localparam int DW = 64;

    localparam logic CFG_MAX_X = 1'b0;
    localparam logic CFG_STEPS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_A, PH_WAIT_B, PH_WAIT_C, PH_INNER, PH_OUTER, PH_SHIFT
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_START_DIV, S_START_WAIT, S_GOLD_MUL, S_GOLD_ADD,
        S_ADV0, S_ADV1, S_ADV2, S_ADV3, S_ADV4, S_ADV5, S_ADV6, S_ADV_WAIT,
        S_ADV8, S_ADV9, S_REGION, S_EMIT
    } t_state;

    function automatic logic signed [XW-1:0] f_clampsym(input logic signed [PW-1:0] v);
        if (v > 68'sd2147483647) return 32'sh7fffffff;
        if (v < -68'sd2147483647) return 32'sh80000001;
        return v[XW-1:0];
    endfunction

    function automatic logic signed [XW-1:0] f_sat32(input logic signed [PW-1:0] v);
        if (v > 68'sd2147483647) return 32'sh7fffffff;
        if (v < -68'sd2147483648) return 32'sh80000000;
        return v[XW-1:0];
    endfunction

endpackage

[rtl/bms_req_if.sv]
// Input channel of the bracket minimum search unit: command and returned cost.
// No dependencies.
interface bms_req_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [31:0] cost_value;

    modport source(output valid, cmd, cost_value, input ready);
    modport sink(input valid, cmd, cost_value, output ready);
endinterface

[rtl/bms_res_if.sv]
// Result channel of the bracket minimum search unit: probe request or bracket.
// No dependencies.
interface bms_res_if;
    logic               valid;
    logic               ready;
    logic               finished;
    logic signed [31:0] probe_point;
    logic signed [31:0] bracket_low;
    logic signed [31:0] bracket_best;
    logic signed [31:0] bracket_high;

    modport source(output valid, finished, probe_point, bracket_low, bracket_best,
                   bracket_high, input ready);
    modport sink(input valid, finished, probe_point, bracket_low, bracket_best,
                 bracket_high, output ready);
endinterface

[rtl/bms_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on bms_pkg.
module bms_div
    import bms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quo
);
    logic          r_busy, r_done, r_neg;
    logic [5:0]    r_cnt;
    logic [DW-1:0] r_quo, r_rem, r_den;
    logic [DW-1:0] a_num, a_den;
    logic [DW:0]   trial;

    assign a_num = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign a_den = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign trial = {1'b0, r_rem[DW-2:0], r_quo[DW-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= a_num;
                r_rem  <= '0;
                r_den  <= a_den;
                r_neg  <= i_num[DW-1] ^ i_den[DW-1];
            end else if (r_busy) begin
                if (!trial[DW]) begin
                    r_rem <= trial[DW-1:0];
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                end
                r_quo <= {r_quo[DW-2:0], ~trial[DW]};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

[rtl/bracket_minimum_search_unit.sv]
// Bracket minimum search unit: top level, sequencer and shared multiplier.
// Depends on bms_pkg, bms_req_if, bms_res_if, bms_div and the assertion header.
//
// The block brackets the minimum of an outside cost function in Q format with
// FRAC_BITS fractional bits. A start command (cmd 0) returns a request for the
// cost at 0; each cost transfer (cmd 1) returns the next point to evaluate or,
// once the middle cost is no larger than the outer one, the bracket low, best
// and high. One item is worked on at a time and the input is not ready
// meanwhile. A start uses the divider to form max_x / step_count. A cost that
// fits a parabola makes five or six passes through the one registered 34 x 34
// multiplier plus one pass through the divider. A waiting result is held in
// the output register while the next item is taken.
`include "bracket_minimum_search_unit_assert.svh"
module bracket_minimum_search_unit
    import bms_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int GROW_LIMIT = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    bms_req_if.sink     i_in,
    bms_res_if.source   o_out
);
    localparam longint GOLD_L = ((64'sd1618034 <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    localparam logic signed [MW-1:0] GOLD_M = MW'(GOLD_L);
    localparam logic signed [MW-1:0] GROW_M = MW'(GROW_LIMIT);
    localparam logic signed [PW-1:0] HALF_P = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic [31:0]          HALF_X = 32'(HALF_P);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic signed [XW-1:0] r_pa, n_pa, r_pb, n_pb, r_pc, n_pc, r_pn, n_pn;
    logic signed [XW-1:0] r_ca, n_ca, r_cb, n_cb, r_cc, n_cc, r_fn, n_fn;
    logic signed [XW-1:0] r_dx12, n_dx12, r_dx10, n_dx10, r_rq, n_rq, r_qq, n_qq;
    logic signed [XW-1:0] r_xlim, n_xlim, r_emit_pt, n_emit_pt;
    logic signed [DW-1:0] r_acc, n_acc;
    logic                 r_cmd, n_cmd, r_gold_first, n_gold_first;
    logic                 r_emit_fin, n_emit_fin;
    logic [30:0]          r_max_x;
    logic [15:0]          r_steps;
    logic signed [PW-1:0] r_prod;
    logic                 r_ovalid, n_ovalid, r_ofin, n_ofin;
    logic signed [XW-1:0] r_opt, n_opt, r_olo, n_olo, r_obest, n_obest, r_ohi, n_ohi;

    logic signed [MW-1:0] mul_a, mul_b;
    logic                 div_start, div_done;
    logic signed [DW-1:0] div_num, div_den, div_quo;
    logic signed [PW-1:0] qsh;
    logic signed [XW-1:0] gbase, gfrom, gres;
    logic signed [XW:0]   dd, dmag;
    logic                 in_ready, t_inner, t_outer, t_lim;

    bms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign in_ready = (r_state == S_IDLE);
    assign qsh   = (r_prod + HALF_P) >>> FRAC_BITS;
    assign gbase = r_gold_first ? r_pb : r_pc;
    assign gfrom = r_gold_first ? r_pa : r_pb;
    assign gres  = f_sat32(PW'(gbase) + qsh);
    assign dd    = (XW+1)'(r_qq) - (XW+1)'(r_rq);
    assign dmag  = (dd < 0) ? -dd : ((dd == 0) ? 33'sd1 : dd);

    assign t_inner = (r_pb > r_pn && r_pn > r_pc) || (r_pb < r_pn && r_pn < r_pc);
    assign t_outer = (r_pc > r_pn && r_pn > r_xlim) || (r_pc < r_pn && r_pn < r_xlim);
    assign t_lim   = !((r_pn > r_xlim && r_xlim < r_pc) || (r_pn < r_xlim && r_xlim > r_pc));

    always_comb begin
        n_state = r_state;   n_phase = r_phase;
        n_pa = r_pa; n_pb = r_pb; n_pc = r_pc; n_pn = r_pn;
        n_ca = r_ca; n_cb = r_cb; n_cc = r_cc; n_fn = r_fn; n_cmd = r_cmd;
        n_dx12 = r_dx12; n_dx10 = r_dx10; n_rq = r_rq; n_qq = r_qq;
        n_xlim = r_xlim; n_acc = r_acc; n_gold_first = r_gold_first;
        n_emit_fin = r_emit_fin; n_emit_pt = r_emit_pt;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ofin = r_ofin; n_opt = r_opt; n_olo = r_olo; n_obest = r_obest; n_ohi = r_ohi;
        mul_a = '0; mul_b = '0;
        div_start = 1'b0; div_num = '0; div_den = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_fn    = i_in.cost_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!r_cmd) begin
                    n_state = S_START_DIV;
                end else begin
                    unique case (r_phase)
                        PH_WAIT_A: begin
                            n_ca = r_fn;
                            n_emit_fin = 1'b0; n_emit_pt = r_pb; n_phase = PH_WAIT_B;
                            n_state = S_EMIT;
                        end
                        PH_WAIT_B: begin
                            if (r_fn > r_ca) begin
                                n_pa = r_pb; n_pb = r_pa; n_ca = r_fn; n_cb = r_ca;
                            end else begin
                                n_cb = r_fn;
                            end
                            n_gold_first = 1'b1;
                            n_state = S_GOLD_MUL;
                        end
                        PH_WAIT_C: begin
                            n_cc = r_fn;
                            n_state = S_ADV0;
                        end
                        PH_INNER: begin
                            if (r_fn < r_cc) begin
                                n_pa = r_pb; n_pb = r_pn;
                                n_emit_fin = 1'b1; n_phase = PH_IDLE; n_state = S_EMIT;
                            end else if (r_fn > r_cb) begin
                                n_pc = r_pn;
                                n_emit_fin = 1'b1; n_phase = PH_IDLE; n_state = S_EMIT;
                            end else begin
                                n_gold_first = 1'b0; n_state = S_GOLD_MUL;
                            end
                        end
                        PH_OUTER: begin
                            if (r_fn < r_cc) begin
                                n_pb = r_pc; n_pc = r_pn; n_cb = r_cc; n_cc = r_fn;
                                n_gold_first = 1'b0; n_state = S_GOLD_MUL;
                            end else begin
                                n_pa = r_pb; n_pb = r_pc; n_pc = r_pn;
                                n_ca = r_cb; n_cb = r_cc; n_cc = r_fn;
                                n_state = S_ADV0;
                            end
                        end
                        PH_SHIFT: begin
                            n_pa = r_pb; n_pb = r_pc; n_pc = r_pn;
                            n_ca = r_cb; n_cb = r_cc; n_cc = r_fn;
                            n_state = S_ADV0;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_START_DIV: begin
                div_start = 1'b1;
                div_num   = DW'(r_max_x);
                div_den   = (r_steps < 16'd2) ? 64'sd2 : DW'(r_steps);
                n_state   = S_START_WAIT;
            end
            S_START_WAIT: begin
                if (div_done) begin
                    n_pa = '0; n_pc = '0; n_pn = '0;
                    n_pb = (DW'(HALF_X) > div_quo) ? div_quo[XW-1:0] : HALF_X;
                    n_emit_fin = 1'b0; n_emit_pt = '0; n_phase = PH_WAIT_A;
                    n_state = S_EMIT;
                end
            end
            S_GOLD_MUL: begin
                mul_a   = GOLD_M;
                mul_b   = MW'(f_clampsym(PW'(gbase) - PW'(gfrom)));
                n_state = S_GOLD_ADD;
            end
            S_GOLD_ADD: begin
                n_emit_fin = 1'b0; n_emit_pt = gres; n_state = S_EMIT;
                if (r_gold_first) begin
                    n_pc = gres; n_phase = PH_WAIT_C;
                end else begin
                    n_pn = gres; n_phase = PH_SHIFT;
                end
            end
            S_ADV0: begin
                if (!(r_cb > r_cc)) begin
                    n_emit_fin = 1'b1; n_phase = PH_IDLE; n_state = S_EMIT;
                end else begin
                    n_dx12  = f_clampsym(PW'(r_pb) - PW'(r_pc));
                    n_dx10  = f_clampsym(PW'(r_pb) - PW'(r_pa));
                    n_state = S_ADV1;
                end
            end
            S_ADV1: begin
                mul_a = MW'(r_dx10);
                mul_b = MW'(f_clampsym(PW'(r_cb) - PW'(r_cc)));
                n_state = S_ADV2;
            end
            S_ADV2: begin
                n_rq  = f_clampsym(qsh);
                mul_a = MW'(r_dx12);
                mul_b = MW'(f_clampsym(PW'(r_cb) - PW'(r_ca)));
                n_state = S_ADV3;
            end
            S_ADV3: begin
                n_qq    = f_clampsym(qsh);
                n_state = S_ADV4;
            end
            S_ADV4: begin
                mul_a = MW'(r_dx12);
                mul_b = MW'(r_qq);
                n_state = S_ADV5;
            end
            S_ADV5: begin
                n_acc = r_prod[DW-1:0];
                mul_a = MW'(r_dx10);
                mul_b = MW'(r_rq);
                n_state = S_ADV6;
            end
            S_ADV6: begin
                div_start = 1'b1;
                div_num   = r_acc - r_prod[DW-1:0];
                div_den   = (dd < 0) ? -(DW'(dmag) <<< 1) : (DW'(dmag) <<< 1);
                n_state   = S_ADV_WAIT;
            end
            S_ADV_WAIT: begin
                if (div_done) begin
                    n_pn    = f_sat32(PW'(r_pb) - PW'(div_quo));
                    n_state = S_ADV8;
                end
            end
            S_ADV8: begin
                mul_a = GROW_M;
                mul_b = MW'(PW'(r_pc) - PW'(r_pb));
                n_state = S_ADV9;
            end
            S_ADV9: begin
                n_xlim  = f_sat32(PW'(r_pb) + r_prod);
                n_state = S_REGION;
            end
            S_REGION: begin
                n_emit_fin = 1'b0;
                if (t_inner) begin
                    n_emit_pt = r_pn; n_phase = PH_INNER; n_state = S_EMIT;
                end else if (t_outer) begin
                    n_emit_pt = r_pn; n_phase = PH_OUTER; n_state = S_EMIT;
                end else if (t_lim) begin
                    n_pn = r_xlim; n_emit_pt = r_xlim; n_phase = PH_SHIFT;
                    n_state = S_EMIT;
                end else begin
                    n_gold_first = 1'b0; n_state = S_GOLD_MUL;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ofin   = r_emit_fin;
                    n_opt    = r_emit_fin ? '0 : r_emit_pt;
                    n_olo    = r_emit_fin ? r_pa : '0;
                    n_obest  = r_emit_fin ? r_pb : '0;
                    n_ohi    = r_emit_fin ? r_pc : '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_ovalid <= 1'b0;
            r_max_x  <= 31'd6553600;
            r_steps  <= 16'd2;
            r_pa <= '0; r_pb <= '0; r_pc <= '0; r_pn <= '0;
            r_ca <= '0; r_cb <= '0; r_cc <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
            r_pa <= n_pa; r_pb <= n_pb; r_pc <= n_pc; r_pn <= n_pn;
            r_ca <= n_ca; r_cb <= n_cb; r_cc <= n_cc;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_X: r_max_x <= i_cfg_data;
                    CFG_STEPS: r_steps <= i_cfg_data[15:0];
                    default:   r_steps <= r_steps;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        r_fn <= n_fn; r_cmd <= n_cmd;
        r_dx12 <= n_dx12; r_dx10 <= n_dx10; r_rq <= n_rq; r_qq <= n_qq;
        r_xlim <= n_xlim; r_acc <= n_acc; r_gold_first <= n_gold_first;
        r_emit_fin <= n_emit_fin; r_emit_pt <= n_emit_pt;
        r_ofin <= n_ofin; r_opt <= n_opt; r_olo <= n_olo; r_obest <= n_obest; r_ohi <= n_ohi;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.finished     = r_ofin;
    assign o_out.probe_point  = r_opt;
    assign o_out.bracket_low  = r_olo;
    assign o_out.bracket_best = r_obest;
    assign o_out.bracket_high = r_ohi;

    `BMS_ASSERT_NEXT(a_busy_after_transfer, in_ready && i_in.valid, !in_ready)
    `BMS_ASSERT_IMP(a_div_done_awaited, div_done, r_state == S_START_WAIT || r_state == S_ADV_WAIT)
    `BMS_ASSERT_NEXT(a_emit_loads, r_state == S_EMIT && (!r_ovalid || o_out.ready), r_ovalid && in_ready)
endmodule
